// ----- src/fbc_pkg.sv -----
// Shared types and constants for the free block cache.
`default_nettype none
package fbc_pkg;

    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 32;
    localparam int THRESH_W = 4;
    localparam int OCOUNT_W = 5;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 4'd10;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_ALLOC_HIT    = 2'd0,
        ST_ALLOC_MISS   = 2'd1,
        ST_FREE_CACHED  = 2'd2,
        ST_FREE_EVICTED = 2'd3
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_TAKE_RD,
        S_TAKE_CAP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

// ----- src/fbc_ram.sv -----
// Entry store: one write port, one read port with registered read data.
`default_nettype none
module fbc_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 80
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- src/free_block_cache.sv -----
// Free block cache: age-ordered store of freed blocks with first-fit reuse.
//
// Input channel i_valid/o_ready carries one item: an allocation request
// (i_action 0, i_request_bytes) or a free (i_action 1, i_block_address,
// i_block_bytes). Every item yields exactly one result on o_valid/i_ready:
// status, reused or evicted block, and the count of cached blocks after it.
// The threshold register is written through i_cfg_we/i_cfg_wdata.
//
// Items are handled one at a time by a small sequencer around an entry RAM
// with one write and one read port, and one size comparator. Each RAM read
// is issued first and its data is registered after. The steps per item:
//   allocation: straight to the result when the cache is empty or the sum
//               overflows, else a scan oldest first; a hit removes its slot;
//   free: straight to the result for a null address, else the block is
//         cached; the oldest is evicted when the cache is full or the
//         count after the insert exceeds the threshold.
// The result sits in an output register; the next item is accepted while it
// waits, and the sequencer holds its next result until the register frees.
// Synchronous reset empties the cache and loads threshold 10. The RAM needs
// no clearing: only slots below the count are ever read.
`default_nettype none
module free_block_cache #(
    parameter int CAPACITY     = 16,
    parameter int HEADER_BYTES = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [fbc_pkg::THRESH_W-1:0]     i_cfg_wdata,
    input  wire                             i_valid,
    output logic                            o_ready,
    input  wire                             i_action,
    input  wire [fbc_pkg::SIZE_W-1:0]       i_request_bytes,
    input  wire [fbc_pkg::ADDR_W-1:0]       i_block_address,
    input  wire [fbc_pkg::SIZE_W-1:0]       i_block_bytes,
    output logic                            o_valid,
    input  wire                             i_ready,
    output logic [1:0]                      o_status,
    output logic [fbc_pkg::ADDR_W-1:0]      o_result_address,
    output logic [fbc_pkg::SIZE_W-1:0]      o_result_bytes,
    output logic [fbc_pkg::OCOUNT_W-1:0]    o_cached_count
);
    import fbc_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [THRESH_W-1:0]   r_thresh;
    logic [SIZE_W:0]       r_need, n_need;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [SIZE_W-1:0]     r_bytes, n_bytes;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_ins_pend, n_ins_pend;
    t_status               r_status, n_status;
    logic [ADDR_W-1:0]     r_res_addr, n_res_addr;
    logic [SIZE_W-1:0]     r_res_bytes, n_res_bytes;
    logic                  r_ovalid;
    t_status               r_o_status;
    logic [ADDR_W-1:0]     r_o_addr;
    logic [SIZE_W-1:0]     r_o_bytes;
    logic [OCOUNT_W-1:0]   r_o_count;

    logic                  w_accept;
    logic                  w_out_load;
    logic [SIZE_W:0]       w_need_in;
    logic [CNT_W-1:0]      w_idx_nx;
    logic [CNT_W-1:0]      w_count_inc;
    logic                  w_full;
    logic                  w_over_thresh;
    logic                  w_fit;
    logic [CNT_W+OCOUNT_W-1:0] w_count_ext;

    logic                  w_we, w_re;
    logic [IDX_W-1:0]      w_waddr, w_raddr;
    t_entry                w_wdata, w_rdata;

    fbc_ram #(
        .DEPTH (CAPACITY),
        .WIDTH ($bits(t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || i_ready);

    assign w_need_in     = {1'b0, i_request_bytes} + (SIZE_W+1)'(HEADER_BYTES);
    assign w_idx_nx      = CNT_W'(r_idx) + 1'b1;
    assign w_count_inc   = r_count + 1'b1;
    assign w_full        = (r_count == CNT_W'(CAPACITY));
    assign w_over_thresh = {{THRESH_W{1'b0}}, w_count_inc} > {{CNT_W{1'b0}}, r_thresh};
    // shared size comparator
    assign w_fit         = (w_rdata.size >= r_need[SIZE_W-1:0]);
    assign w_count_ext   = {{OCOUNT_W{1'b0}}, r_count};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_ALLOC) begin
                        if (w_need_in[SIZE_W] || r_count == '0) begin
                            n_state = S_OUT;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end else if (i_block_address == '0) begin
                        n_state = S_OUT;
                    end else if (w_full) begin
                        n_state = S_TAKE_RD;
                    end else begin
                        n_state = S_INS;
                    end
                end
            end
            S_SCAN_RD:  n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (w_fit) begin
                    n_state = S_SHIFT_RD;
                end else if (w_idx_nx == r_count) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_TAKE_RD:  n_state = S_TAKE_CAP;
            S_TAKE_CAP: n_state = S_SHIFT_RD;
            S_SHIFT_RD: begin
                if (w_idx_nx < r_count) begin
                    n_state = S_SHIFT_WR;
                end else if (r_ins_pend) begin
                    n_state = S_INS;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_INS: begin
                if (r_status == ST_FREE_CACHED && w_over_thresh) begin
                    n_state = S_TAKE_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and RAM controls
    always_comb begin
        n_count     = r_count;
        n_need      = r_need;
        n_addr      = r_addr;
        n_bytes     = r_bytes;
        n_idx       = r_idx;
        n_ins_pend  = r_ins_pend;
        n_status    = r_status;
        n_res_addr  = r_res_addr;
        n_res_bytes = r_res_bytes;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = w_rdata;
        w_re        = 1'b0;
        w_raddr     = r_idx;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_need      = w_need_in;
                    n_addr      = i_block_address;
                    n_bytes     = i_block_bytes;
                    n_idx       = '0;
                    n_res_addr  = '0;
                    n_res_bytes = '0;
                    n_ins_pend  = 1'b0;
                    if (i_action == ACT_ALLOC) begin
                        n_status = ST_ALLOC_MISS;
                    end else begin
                        n_status   = ST_FREE_CACHED;
                        n_ins_pend = (i_block_address != '0) && w_full;
                    end
                end
            end
            S_SCAN_RD, S_TAKE_RD: begin
                w_re = 1'b1;
            end
            S_SCAN_CMP: begin
                if (w_fit) begin
                    n_status    = ST_ALLOC_HIT;
                    n_res_addr  = w_rdata.addr;
                    n_res_bytes = w_rdata.size;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TAKE_CAP: begin
                n_status    = ST_FREE_EVICTED;
                n_res_addr  = w_rdata.addr;
                n_res_bytes = w_rdata.size;
            end
            S_SHIFT_RD: begin
                if (w_idx_nx < r_count) begin
                    w_re    = 1'b1;
                    w_raddr = r_idx + 1'b1;
                end else begin
                    // slot freed: close the gap
                    n_count = r_count - 1'b1;
                    if (r_ins_pend) begin
                        n_ins_pend = 1'b0;
                    end
                end
            end
            S_SHIFT_WR: begin
                w_we  = 1'b1;
                n_idx = r_idx + 1'b1;
            end
            S_INS: begin
                w_we         = 1'b1;
                w_waddr      = r_count[IDX_W-1:0];
                w_wdata.addr = r_addr;
                w_wdata.size = r_bytes;
                n_count      = w_count_inc;
                n_idx        = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_thresh   <= THRESH_RESET;
            r_ins_pend <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ins_pend <= n_ins_pend;
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_need      <= n_need;
        r_addr      <= n_addr;
        r_bytes     <= n_bytes;
        r_idx       <= n_idx;
        r_status    <= n_status;
        r_res_addr  <= n_res_addr;
        r_res_bytes <= n_res_bytes;
        if (w_out_load) begin
            r_o_status <= r_status;
            r_o_addr   <= r_res_addr;
            r_o_bytes  <= r_res_bytes;
            r_o_count  <= w_count_ext[OCOUNT_W-1:0];
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_o_status;
    assign o_result_address = r_o_addr;
    assign o_result_bytes   = r_o_bytes;
    assign o_cached_count   = r_o_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("cached count exceeds capacity");

    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_count < CNT_W'(CAPACITY)))
        else $error("insert with no free slot");

    a_reuse_nonnull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_ALLOC_HIT || o_status == ST_FREE_EVICTED))
            |-> (o_result_address != '0))
        else $error("reused or evicted block has null address");

    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_ALLOC_MISS || o_status == ST_FREE_CACHED))
            |-> (o_result_address == '0 && o_result_bytes == '0))
        else $error("miss or cached free reports a block");

    a_hit_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CMP && w_fit) |=> (r_count == $past(r_count)))
        else $error("count changed before the hit slot was removed");

endmodule
`default_nettype wire
